FILE: src/f2d_pkg.sv
// Package for the fragment to disk address translator.
// Holds constants, register codes and the word types shared by all modules.
// No dependencies.
package f2d_pkg;

   localparam int FRAGS_PER_BLOCK      = 4;
   localparam int SECTORS_PER_FRAGMENT = 2;
   localparam int OFFSET_DEPTH         = 32;

   localparam int FIB_W   = (FRAGS_PER_BLOCK > 1) ? $clog2(FRAGS_PER_BLOCK) : 1;
   localparam int TIDX_W  = (OFFSET_DEPTH > 1) ? $clog2(OFFSET_DEPTH) : 1;
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int DIV_W   = 33;
   localparam int DVS_W   = 16;

   localparam logic [2:0] CSR_BPC  = 3'd0;
   localparam logic [2:0] CSR_BPRS = 3'd1;
   localparam logic [2:0] CSR_SPT  = 3'd2;
   localparam logic [2:0] CSR_HC   = 3'd3;
   localparam logic [2:0] CSR_TRS  = 3'd4;

   localparam logic REQ_TRANSLATE = 1'b0;
   localparam logic REQ_LOAD      = 1'b1;

   localparam logic [30:0] LIN_MAX  = 31'h7FFF_FFFF;
   localparam logic [28:0] CYL_MAX  = 29'h1FFF_FFFF;
   localparam logic [15:0] HEAD_MAX = 16'hFFFF;

   typedef struct packed {
      logic        req_type;
      logic [30:0] frag_index;
      logic [4:0]  entry_index;
      logic [15:0] entry_offset;
   } f2d_req_type;

   typedef struct packed {
      logic [30:0] linear_sector;
      logic [28:0] cylinder_number;
      logic [15:0] head_number;
      logic [7:0]  track_sector;
      logic        error_flag;
   } f2d_rsp_type;

   // Geometry with zero divisors already mapped to one.
   typedef struct packed {
      logic [15:0] bpc;
      logic [7:0]  bprs;
      logic [7:0]  spt;
      logic [7:0]  hc;
      logic [7:0]  trs;
   } f2d_cfg_type;

   // Classified word handed from the front to the back.
   typedef struct packed {
      logic             is_load;
      logic [30:0]      block;
      logic [FIB_W-1:0] fib;
      logic [4:0]       entry_index;
      logic [15:0]      entry_offset;
      logic             err;
   } f2d_item_type;

   // Context that travels down the back pipeline beside the data.
   typedef struct packed {
      f2d_item_type     item;
      logic [30:0]      cyl;
      logic [15:0]      set;
      logic [15:0]      off;
      logic [15:0]      pa;
      logic [15:0]      pb;
      logic [31:0]      smul;
      logic [46:0]      cmul;
      logic [DIV_W-1:0] in_set;
      logic [30:0]      lin;
   } f2d_ctx_type;

endpackage

FILE: src/fragment_to_disk_address.sv
// Each accepted request word passes three 33-stage pipelined dividers (cylinder,
// set, head) plus seven stages on its way to its result word.
// Throughput: one word per cycle; the dividers take a new word every cycle unless the
// result side stalls. A four-word queue parts the front from the back; while the
// result side stalls the back holds still and push stays open until that queue is
// full. Reset is synchronous and active high; the geometry registers return to one
// and the offset table holds nothing valid until loaded.
module fragment_to_disk_address (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  f2d_pkg::f2d_req_type req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output f2d_pkg::f2d_rsp_type rsp_data,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_wdata
);
   import f2d_pkg::*;

   logic [15:0]   bpc_ff;
   logic [7:0]    bprs_ff, spt_ff, hc_ff, trs_ff;
   f2d_cfg_type   cfg;
   logic          q_valid, q_pop;
   f2d_item_type  q_item;

   // Geometry registers. Writes must arrive only while idle; the block does not check it.
   always_ff @(posedge clock) begin
      if (reset) begin
         bpc_ff  <= 16'd1;
         bprs_ff <= 8'd1;
         spt_ff  <= 8'd1;
         hc_ff   <= 8'd1;
         trs_ff  <= 8'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BPC:  bpc_ff  <= csr_wdata;
            CSR_BPRS: bprs_ff <= csr_wdata[7:0];
            CSR_SPT:  spt_ff  <= csr_wdata[7:0];
            CSR_HC:   hc_ff   <= csr_wdata[7:0];
            CSR_TRS:  trs_ff  <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // A zero divisor is treated as one, so the dividers never see zero.
   always_comb begin
      cfg.bpc  = (bpc_ff == '0) ? 16'd1 : bpc_ff;
      cfg.bprs = (bprs_ff == '0) ? 8'd1 : bprs_ff;
      cfg.spt  = (spt_ff == '0) ? 8'd1 : spt_ff;
      cfg.hc   = hc_ff;
      cfg.trs  = trs_ff;
   end

   f2d_front u_front (
      .clock, .reset, .req_push, .req_full, .req_data,
      .q_valid, .q_item, .q_pop
   );

   f2d_back u_back (
      .clock, .reset, .cfg, .q_valid, .q_item, .q_pop,
      .rsp_empty, .rsp_pop, .rsp_data
   );

endmodule

FILE: src/f2d_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a stall enable.
// A context word rides along each stage. Depends on f2d_pkg.
module f2d_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [f2d_pkg::DIV_W-1:0] dividend,
   input  logic [f2d_pkg::DVS_W-1:0] divisor,
   input  f2d_pkg::f2d_ctx_type      ctx_in,
   output logic                      out_valid,
   output logic [f2d_pkg::DIV_W-1:0] quotient,
   output logic [f2d_pkg::DVS_W-1:0] remainder,
   output f2d_pkg::f2d_ctx_type      ctx_out
);
   import f2d_pkg::*;

   logic             s_v [0:DIV_W];
   logic [DVS_W-1:0] s_r [0:DIV_W];
   logic [DIV_W-1:0] s_n [0:DIV_W];
   logic [DVS_W-1:0] s_d [0:DIV_W];
   f2d_ctx_type      s_c [0:DIV_W];

   assign s_v[0] = in_valid;
   assign s_r[0] = '0;
   assign s_n[0] = dividend;
   assign s_d[0] = divisor;
   assign s_c[0] = ctx_in;

   for (genvar i = 0; i < DIV_W; i++) begin : g_stage
      logic             v_ff;
      logic [DVS_W-1:0] r_ff, r_in, d_ff;
      logic [DIV_W-1:0] n_ff, n_in;
      f2d_ctx_type      c_ff;
      logic [DVS_W:0]   trial;
      logic [DVS_W:0]   diff;
      logic             ge;

      // The partial remainder shifts in the next dividend bit; the quotient bit
      // shifts into the low end of the dividend word as it empties.
      assign trial = {s_r[i], s_n[i][DIV_W-1]};
      assign ge    = trial >= {1'b0, s_d[i]};
      assign diff  = trial - {1'b0, s_d[i]};
      assign r_in  = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      assign n_in  = {s_n[i][DIV_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (en) begin
            v_ff <= s_v[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff <= r_in;
            n_ff <= n_in;
            d_ff <= s_d[i];
            c_ff <= s_c[i];
         end
      end

      assign s_v[i+1] = v_ff;
      assign s_r[i+1] = r_ff;
      assign s_n[i+1] = n_ff;
      assign s_d[i+1] = d_ff;
      assign s_c[i+1] = c_ff;
   end

   assign out_valid = s_v[DIV_W];
   assign quotient  = s_n[DIV_W];
   assign remainder = s_r[DIV_W];
   assign ctx_out   = s_c[DIV_W];

endmodule

FILE: src/f2d_front.sv
// Front end: accepts request words, classifies them and queues them for the back.
// Depends on f2d_pkg.
module f2d_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  f2d_pkg::f2d_req_type  req_data,
   output logic                  q_valid,
   output f2d_pkg::f2d_item_type q_item,
   input  logic                  q_pop
);
   import f2d_pkg::*;

   f2d_item_type      mem_ff [0:QDEPTH-1];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;
   f2d_item_type      item;
   logic              push_ok;

   always_comb begin
      item.is_load      = req_data.req_type == REQ_LOAD;
      item.block        = 31'(req_data.frag_index / FRAGS_PER_BLOCK);
      item.fib          = FIB_W'(req_data.frag_index % FRAGS_PER_BLOCK);
      item.entry_index  = req_data.entry_index;
      item.entry_offset = req_data.entry_offset;
      item.err          = item.is_load && (32'(req_data.entry_index) >= OFFSET_DEPTH);
   end

   assign req_full = cnt_ff == (QPTR_W+1)'(QDEPTH);
   assign push_ok  = req_push && !req_full;
   assign q_valid  = cnt_ff != '0;
   assign q_item   = mem_ff[rd_ff];

   assign wr_in  = push_ok ? wr_ff + 1'b1 : wr_ff;
   assign rd_in  = q_pop ? rd_ff + 1'b1 : rd_ff;
   assign cnt_in = cnt_ff + (QPTR_W+1)'(push_ok) - (QPTR_W+1)'(q_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ff] <= item;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QPTR_W+1)'(QDEPTH)) else $error("queue overfilled");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_push_grow: assert property (@(posedge clock) disable iff (reset)
      (push_ok && !q_pop) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("accepted word not counted");

endmodule

FILE: src/f2d_back.sv
// Back end: divides out cylinder, set and head, reads and loads the offset table and
// forms the result word. Depends on f2d_pkg and f2d_div.
module f2d_back (
   input  logic                  clock,
   input  logic                  reset,
   input  f2d_pkg::f2d_cfg_type  cfg,
   input  logic                  q_valid,
   input  f2d_pkg::f2d_item_type q_item,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output f2d_pkg::f2d_rsp_type  rsp_data
);
   import f2d_pkg::*;

   logic        adv;
   logic        b0_v_ff, t_v_ff, m1_v_ff, m2_v_ff, a_v_ff, l_v_ff, o_v_ff;
   f2d_ctx_type b0_c_ff, b0_c_in, t_c_ff, t_c_in, m1_c_ff, m1_c_in;
   f2d_ctx_type m2_c_ff, m2_c_in, a_c_ff, a_c_in, l_c_ff, l_c_in;
   f2d_rsp_type o_ff, o_in;
   logic [15:0] table_ff [0:OFFSET_DEPTH-1];

   logic             d1_v, d2_v, d3_v;
   logic [DIV_W-1:0] d1_q, d2_q, d3_q;
   logic [DVS_W-1:0] d1_r, d2_r, d3_r;
   f2d_ctx_type      d1_c, d2_c, d3_c, d2_cin;
   logic [47:0]      lin_sum;

   // The whole pipeline moves whenever the result register is free or drained.
   assign adv       = !o_v_ff || rsp_pop;
   assign q_pop     = adv && q_valid;
   assign rsp_empty = !o_v_ff;
   assign rsp_data  = o_ff;

   always_comb begin
      b0_c_in      = '0;
      b0_c_in.item = q_item;
   end

   f2d_div u_div_cyl (
      .clock, .reset, .en(adv), .in_valid(b0_v_ff),
      .dividend({2'b00, b0_c_ff.item.block}), .divisor(cfg.bpc), .ctx_in(b0_c_ff),
      .out_valid(d1_v), .quotient(d1_q), .remainder(d1_r), .ctx_out(d1_c)
   );

   always_comb begin
      d2_cin     = d1_c;
      d2_cin.cyl = d1_q[30:0];
   end

   f2d_div u_div_set (
      .clock, .reset, .en(adv), .in_valid(d1_v),
      .dividend({17'd0, d1_r}), .divisor({8'd0, cfg.bprs}), .ctx_in(d2_cin),
      .out_valid(d2_v), .quotient(d2_q), .remainder(d2_r), .ctx_out(d2_c)
   );

   // Offset table: read and written at the same stage so words stay in order.
   always_comb begin
      t_c_in     = d2_c;
      t_c_in.set = d2_q[15:0];
      if (32'(d2_r) < OFFSET_DEPTH) begin
         t_c_in.off = table_ff[d2_r[TIDX_W-1:0]];
      end else begin
         t_c_in.off = '0;
         if (!d2_c.item.is_load) begin
            t_c_in.item.err = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && d2_v && d2_c.item.is_load && !d2_c.item.err) begin
         table_ff[d2_c.item.entry_index[TIDX_W-1:0]] <= d2_c.item.entry_offset;
      end
   end

   always_comb begin
      m1_c_in    = t_c_ff;
      m1_c_in.pa = 16'(cfg.spt * cfg.trs);
      m1_c_in.pb = 16'(cfg.spt * cfg.hc);
   end

   always_comb begin
      m2_c_in      = m1_c_ff;
      m2_c_in.smul = 32'(m1_c_ff.pa * m1_c_ff.set);
      m2_c_in.cmul = 47'(m1_c_ff.pb * m1_c_ff.cyl);
   end

   always_comb begin
      a_c_in        = m2_c_ff;
      a_c_in.in_set = DIV_W'(m2_c_ff.smul) + DIV_W'(m2_c_ff.off)
                      + DIV_W'(m2_c_ff.item.fib * SECTORS_PER_FRAGMENT);
   end

   // Load words carry a meaningless block, so only translates may flag overflow.
   always_comb begin
      l_c_in  = a_c_ff;
      lin_sum = {1'b0, a_c_ff.cmul} + 48'(a_c_ff.in_set);
      if (lin_sum > 48'(LIN_MAX)) begin
         l_c_in.lin = LIN_MAX;
         if (!a_c_ff.item.is_load) begin
            l_c_in.item.err = 1'b1;
         end
      end else begin
         l_c_in.lin = lin_sum[30:0];
      end
   end

   f2d_div u_div_head (
      .clock, .reset, .en(adv), .in_valid(l_v_ff),
      .dividend(l_c_ff.in_set), .divisor({8'd0, cfg.spt}), .ctx_in(l_c_ff),
      .out_valid(d3_v), .quotient(d3_q), .remainder(d3_r), .ctx_out(d3_c)
   );

   always_comb begin
      o_in            = '0;
      o_in.error_flag = d3_c.item.err;
      if (!d3_c.item.is_load) begin
         o_in.linear_sector = d3_c.lin;
         o_in.track_sector  = d3_r[7:0];
         if (d3_q > DIV_W'(HEAD_MAX)) begin
            o_in.head_number = HEAD_MAX;
            o_in.error_flag  = 1'b1;
         end else begin
            o_in.head_number = d3_q[15:0];
         end
         if (d3_c.cyl > 31'(CYL_MAX)) begin
            o_in.cylinder_number = CYL_MAX;
            o_in.error_flag      = 1'b1;
         end else begin
            o_in.cylinder_number = d3_c.cyl[28:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_v_ff <= 1'b0;
         t_v_ff  <= 1'b0;
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
         a_v_ff  <= 1'b0;
         l_v_ff  <= 1'b0;
         o_v_ff  <= 1'b0;
      end else if (adv) begin
         b0_v_ff <= q_valid;
         t_v_ff  <= d2_v;
         m1_v_ff <= t_v_ff;
         m2_v_ff <= m1_v_ff;
         a_v_ff  <= m2_v_ff;
         l_v_ff  <= a_v_ff;
         o_v_ff  <= d3_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b0_c_ff <= b0_c_in;
         t_c_ff  <= t_c_in;
         m1_c_ff <= m1_c_in;
         m2_c_ff <= m2_c_in;
         a_c_ff  <= a_c_in;
         l_c_ff  <= l_c_in;
         o_ff    <= o_in;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (o_v_ff && !rsp_pop) |=> o_v_ff && $stable(o_ff)) else $error("result word lost");
   a_no_pop_stall: assert property (@(posedge clock) disable iff (reset)
      (o_v_ff && !rsp_pop) |-> !q_pop) else $error("queue popped while stalled");
   a_load_zero: assert property (@(posedge clock) disable iff (reset)
      (adv && d3_v && d3_c.item.is_load) |=> o_ff.linear_sector == '0)
      else $error("load word carries a sector");

endmodule

FILE: tb/sv/fragment_to_disk_address_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the fragment to disk address translator.
// Needs f2d_pkg, fragment_to_disk_address, f2d_front, f2d_back, f2d_div.

module fragment_to_disk_address_tb;
   import f2d_pkg::*;

   // Address calculator and store of the disk addresses still to come.
   class disk_addr_scoreboard;
      logic [15:0] bpc;
      logic [7:0]  bprs, spt, hc, trs;
      logic [15:0] offsets [OFFSET_DEPTH];
      f2d_rsp_type pending_addrs [$];
      int errors, translates, loads, flagged, checked;

      function new();
         bpc = 1; bprs = 1; spt = 1; hc = 1; trs = 1;
         errors = 0; translates = 0; loads = 0; flagged = 0; checked = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [15:0] v);
         case (idx)
            CSR_BPC:  bpc  = v;
            CSR_BPRS: bprs = v[7:0];
            CSR_SPT:  spt  = v[7:0];
            CSR_HC:   hc   = v[7:0];
            CSR_TRS:  trs  = v[7:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return pending_addrs.size();
      endfunction

      function void note_input(f2d_req_type r);
         longint unsigned d_bpc, d_bprs, d_spt, block, cyl, rem, set_no, bi, off;
         longint unsigned in_set, lin, head;
         f2d_rsp_type e;
         e = '0;
         if (r.req_type == REQ_LOAD) begin
            loads++;
            if (r.entry_index < OFFSET_DEPTH) offsets[r.entry_index] = r.entry_offset;
            else e.error_flag = 1'b1;
         end else begin
            translates++;
            d_bpc  = (bpc  == 0) ? 1 : bpc;
            d_bprs = (bprs == 0) ? 1 : bprs;
            d_spt  = (spt  == 0) ? 1 : spt;
            block  = r.frag_index / FRAGS_PER_BLOCK;
            cyl    = block / d_bpc;
            rem    = block - cyl * d_bpc;
            set_no = rem / d_bprs;
            bi     = rem - set_no * d_bprs;
            if (bi < OFFSET_DEPTH) begin
               off = offsets[bi];
            end else begin
               off = 0;
               e.error_flag = 1'b1;
            end
            in_set = d_spt * trs * set_no + off
                     + (r.frag_index % FRAGS_PER_BLOCK) * SECTORS_PER_FRAGMENT;
            lin = d_spt * hc * cyl + in_set;
            if (lin > LIN_MAX) begin
               lin = LIN_MAX;
               e.error_flag = 1'b1;
            end
            head = in_set / d_spt;
            e.track_sector = 8'(in_set - head * d_spt);
            if (head > HEAD_MAX) begin
               head = HEAD_MAX;
               e.error_flag = 1'b1;
            end
            if (cyl > CYL_MAX) begin
               cyl = CYL_MAX;
               e.error_flag = 1'b1;
            end
            e.linear_sector   = 31'(lin);
            e.cylinder_number = 29'(cyl);
            e.head_number     = 16'(head);
            if (e.error_flag) flagged++;
         end
         pending_addrs.push_back(e);
      endfunction

      function void compare_field(string name, longint unsigned exp_v, longint unsigned act_v);
         if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
         end
      endfunction

      function void check_result(f2d_rsp_type a);
         f2d_rsp_type e;
         if (pending_addrs.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, got %h", $time, a);
            return;
         end
         e = pending_addrs.pop_front();
         checked++;
         compare_field("linear_sector",   e.linear_sector,   a.linear_sector);
         compare_field("cylinder_number", e.cylinder_number, a.cylinder_number);
         compare_field("head_number",     e.head_number,     a.head_number);
         compare_field("track_sector",    e.track_sector,    a.track_sector);
         compare_field("error_flag",      e.error_flag,      a.error_flag);
      endfunction
   endclass

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 130;
   localparam int RANDOM_PER_SET = 150;

   logic        clock, reset;
   logic        req_push, req_full;
   f2d_req_type req_data;
   logic        rsp_empty, rsp_pop;
   f2d_rsp_type rsp_data;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   // Copies of the handshake signals taken just before each rising edge.
   logic        s_push, s_full, s_empty, s_pop;
   f2d_req_type s_req;
   f2d_rsp_type s_rsp;

   disk_addr_scoreboard sb = new();
   int  idle_cycles = 0;
   bit  hold_go = 0;
   int  burst_left = 0;

   fragment_to_disk_address u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // The clock generator snapshots every handshake signal right before the
   // rising edge, so the monitor and the driver see the pre-edge values no
   // matter how the simulator orders the events of that time step.
   initial clock = 1'b0;
   always begin
      #6;
      if (!clock) begin
         s_push  = req_push;
         s_full  = req_full;
         s_req   = req_data;
         s_pop   = rsp_pop;
         s_empty = rsp_empty;
         s_rsp   = rsp_data;
      end
      clock = ~clock;
   end

   // Monitor: every accepted request word goes into the address calculator,
   // every accepted result word is checked against the oldest expectation.
   // The watchdog ends the run when nothing moves for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if (s_push && !s_full) sb.note_input(s_req);
         if (s_pop && !s_empty) sb.check_result(s_rsp);
         if ((s_push && !s_full) || (s_pop && !s_empty)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Receiver: stretch by stretch, the pop pattern picks at random between
   // always ready, mostly ready and mostly stalled. A request from the main
   // process starts one long hold-off, counted here, so the queue fills up.
   initial begin
      int hold_cnt, mood, mood_cnt;
      hold_cnt = 0;
      mood = 0;
      mood_cnt = 0;
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (mood_cnt == 0) begin
            mood = $urandom_range(0, 2);
            mood_cnt = 64;
         end
         mood_cnt--;
         if (hold_go) begin
            hold_go = 0;
            hold_cnt = HOLD_CYCLES;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_pop <= 1'b0;
         end else begin
            case (mood)
               0:       rsp_pop <= 1'b1;
               1:       rsp_pop <= ($urandom_range(0, 3) != 0);
               default: rsp_pop <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Offers one word from a falling edge until it is taken; returns at the
   // falling edge after acceptance with push still high.
   task automatic push_word(f2d_req_type w);
      req_push <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (s_full);
      @(negedge clock);
   endtask

   // Sender in bursts: when a burst runs out, the line goes quiet for a
   // random gap (sometimes none) before the next burst starts.
   task automatic push_bursty(f2d_req_type w);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      push_word(w);
   endtask

   function automatic f2d_req_type translate_word(logic [30:0] frag);
      f2d_req_type w;
      w = '0;
      w.req_type     = REQ_TRANSLATE;
      w.frag_index   = frag;
      w.entry_index  = 5'($urandom);
      w.entry_offset = 16'($urandom);
      return w;
   endfunction

   function automatic f2d_req_type load_word(logic [4:0] idx, logic [15:0] off);
      f2d_req_type w;
      w.req_type     = REQ_LOAD;
      w.frag_index   = 31'($urandom);
      w.entry_index  = idx;
      w.entry_offset = off;
      return w;
   endfunction

   function automatic logic [30:0] random_frag();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) return 31'($urandom);
      if (pick < 8) return 31'($urandom_range(0, 8191));
      return 31'h7FFF_FFFF - 31'($urandom_range(0, 4095));
   endfunction

   // Waits until every expected word has arrived and the pipeline is quiet,
   // which is the only time the geometry registers may change.
   task automatic drain();
      req_push <= 1'b0;
      while (sb.pending() > 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_geometry(logic [15:0] v_bpc, logic [15:0] v_bprs, logic [15:0] v_spt,
                               logic [15:0] v_hc, logic [15:0] v_trs);
      logic [15:0] vals [5];
      vals = '{v_bpc, v_bprs, v_spt, v_hc, v_trs};
      for (int i = 0; i < 5; i++) begin
         csr_we    <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
         sb.write_reg(3'(i), vals[i]);
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [30:0] edge_frags [8];
      reset     = 1'b1;
      req_push  = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_BPC;
      csr_wdata = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Fill the whole offset table first, so no translate ever reads an
      // entry that was never written. The first and last entries get the
      // extreme offsets.
      for (int i = 0; i < OFFSET_DEPTH; i++) begin
         if (i == 0) push_word(load_word(5'(i), 16'h0000));
         else if (i == OFFSET_DEPTH - 1) push_word(load_word(5'(i), 16'hFFFF));
         else push_word(load_word(5'(i), 16'($urandom)));
      end

      // Six geometry settings: the reset values, all registers at their
      // maximum, all at zero (zero divisors count as one), a small geometry
      // whose rotational sets run past the table, a wide track with tiny
      // sets, and a random one.
      for (int phase = 0; phase < 6; phase++) begin
         drain();
         case (phase)
            0: ;
            1: set_geometry(16'hFFFF, 16'd255, 16'd255, 16'd255, 16'd255);
            2: set_geometry(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
            3: set_geometry(16'd40, 16'd50, 16'd7, 16'd3, 16'd9);
            4: set_geometry(16'd1, 16'd1, 16'd255, 16'd255, 16'd1);
            default: set_geometry(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 255)),
                                  16'($urandom_range(1, 255)), 16'($urandom_range(1, 255)),
                                  16'($urandom_range(1, 255)));
         endcase

         // Directed corners of the fragment index: zero, each fragment within
         // the first block, the next one, the midpoint and the top of the range.
         edge_frags = '{31'd0, 31'd1, 31'd2, 31'd3, 31'd4,
                        31'h7FFF_FFFF, 31'h7FFF_FFFC, 31'h4000_0000};
         foreach (edge_frags[i]) push_word(translate_word(edge_frags[i]));

         // With maximum geometry the receiver stops for a long stretch while
         // words keep coming, so the block fills and raises full.
         if (phase == 1) hold_go = 1;

         // Mostly translates, with table reloads sprinkled in between.
         for (int n = 0; n < RANDOM_PER_SET; n++) begin
            if ($urandom_range(0, 6) == 0)
               push_bursty(load_word(5'($urandom), 16'($urandom)));
            else
               push_bursty(translate_word(random_frag()));
         end
      end

      drain();
      $display("Covered %0d translates and %0d table loads over six geometries;",
               sb.translates, sb.loads);
      $display("%0d words checked, %0d of them with the error flag expected.",
               sb.checked, sb.flagged);
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
